### hw/rtl/spq_pkg.sv
package spq_pkg;

   // request opcodes
   localparam logic [1:0] OP_INSERT     = 2'd0;
   localparam logic [1:0] OP_REMOVE_PRI = 2'd1;
   localparam logic [1:0] OP_REMOVE_MAX = 2'd2;
   localparam logic [1:0] OP_CLEAR      = 2'd3;

   // response status codes
   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_REMOVED  = 3'd1;
   localparam logic [2:0] ST_NOMATCH  = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;
   localparam logic [2:0] ST_CLEARED  = 3'd5;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  prio;
   } entry_type;

   typedef enum logic [2:0] {RD_NONE, RD_TOP, RD_ZERO, RD_DN, RD_UP} rd_op_type;
   typedef enum logic [2:0] {WR_NONE, WR_SHIFT, WR_NEW_ABOVE, WR_NEW_ZERO, WR_KEEP} wr_op_type;
   typedef enum logic [1:0] {TGT_NONE, TGT_REQ, TGT_DATA} tgt_op_type;
   typedef enum logic [1:0] {CNT_NONE, CNT_CLEAR, CNT_INC_MATCH} cnt_op_type;
   typedef enum logic [1:0] {FILL_NONE, FILL_INC, FILL_CLEAR, FILL_SUB_CNT} fill_op_type;
   typedef enum logic [1:0] {EMIT_NONE, EMIT_STATUS, EMIT_REMOVED} emit_op_type;

   typedef struct packed {
      logic        latch_req;
      rd_op_type   rd_op;
      wr_op_type   wr_op;
      tgt_op_type  tgt_op;
      cnt_op_type  cnt_op;
      fill_op_type fill_op;
      emit_op_type emit_op;
      logic [2:0]  status;
   } cmd_type;

   typedef struct packed {
      logic fill_zero;
      logic full;
      logic match;
      logic greater;
      logic rd_zero;
      logic at_end;
      logic none_found;
   } sts_type;

endpackage

### hw/rtl/spq_ctrl.sv
module spq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_opcode,
   input  spq_pkg::sts_type sts,
   output logic             busy,
   output spq_pkg::cmd_type cmd
);
   import spq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_INS_SCAN, S_INS_PUT, S_RM_TGT, S_CNT_SCAN, S_RM_SCAN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      cmd = '{latch_req: 1'b0, rd_op: RD_NONE, wr_op: WR_NONE, tgt_op: TGT_NONE,
              cnt_op: CNT_NONE, fill_op: FILL_NONE, emit_op: EMIT_NONE,
              status: ST_INSERTED};
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               unique case (req_opcode) inside
                  OP_INSERT: begin
                     if (sts.full) begin
                        cmd.emit_op = EMIT_STATUS;
                        cmd.status  = ST_FULL;
                     end else if (sts.fill_zero) begin
                        state_in = S_INS_PUT;
                     end else begin
                        cmd.rd_op = RD_TOP;
                        state_in  = S_INS_SCAN;
                     end
                  end
                  OP_REMOVE_PRI, OP_REMOVE_MAX: begin
                     if (sts.fill_zero) begin
                        cmd.emit_op = EMIT_STATUS;
                        cmd.status  = ST_EMPTY;
                     end else if (req_opcode == OP_REMOVE_MAX) begin
                        // the maximum sits in the top entry
                        cmd.rd_op = RD_TOP;
                        state_in  = S_RM_TGT;
                     end else begin
                        cmd.tgt_op = TGT_REQ;
                        cmd.rd_op  = RD_ZERO;
                        cmd.cnt_op = CNT_CLEAR;
                        state_in   = S_CNT_SCAN;
                     end
                  end
                  default: begin
                     cmd.fill_op = FILL_CLEAR;
                     cmd.emit_op = EMIT_STATUS;
                     cmd.status  = ST_CLEARED;
                  end
               endcase
            end
         end
         S_INS_SCAN: begin
            // walk down from the top, shifting larger entries up one slot
            if (sts.greater) begin
               cmd.wr_op = WR_SHIFT;
               if (sts.rd_zero) begin
                  state_in = S_INS_PUT;
               end else begin
                  cmd.rd_op = RD_DN;
               end
            end else begin
               cmd.wr_op   = WR_NEW_ABOVE;
               cmd.fill_op = FILL_INC;
               cmd.emit_op = EMIT_STATUS;
               cmd.status  = ST_INSERTED;
               state_in    = S_IDLE;
            end
         end
         S_INS_PUT: begin
            cmd.wr_op   = WR_NEW_ZERO;
            cmd.fill_op = FILL_INC;
            cmd.emit_op = EMIT_STATUS;
            cmd.status  = ST_INSERTED;
            state_in    = S_IDLE;
         end
         S_RM_TGT: begin
            cmd.tgt_op = TGT_DATA;
            cmd.rd_op  = RD_ZERO;
            cmd.cnt_op = CNT_CLEAR;
            state_in   = S_CNT_SCAN;
         end
         S_CNT_SCAN: begin
            // first pass counts matches so occupancy and last are known
            cmd.cnt_op = CNT_INC_MATCH;
            if (sts.at_end) begin
               if (sts.none_found) begin
                  cmd.emit_op = EMIT_STATUS;
                  cmd.status  = ST_NOMATCH;
                  state_in    = S_IDLE;
               end else begin
                  cmd.rd_op = RD_ZERO;
                  state_in  = S_RM_SCAN;
               end
            end else begin
               cmd.rd_op = RD_UP;
            end
         end
         S_RM_SCAN: begin
            if (sts.match) begin
               cmd.emit_op = EMIT_REMOVED;
            end else begin
               cmd.wr_op = WR_KEEP;
            end
            if (sts.at_end) begin
               cmd.fill_op = FILL_SUB_CNT;
               state_in    = S_IDLE;
            end else begin
               cmd.rd_op = RD_UP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

### hw/rtl/spq_datapath.sv
module spq_datapath #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  spq_pkg::cmd_type cmd,
   input  logic [15:0]      req_proc_id,
   input  logic [7:0]       req_priority_req,
   output spq_pkg::sts_type sts,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [15:0]      rsp_out_id,
   output logic [7:0]       rsp_out_priority,
   output logic             rsp_last,
   output logic [6:0]       rsp_occupancy
);
   import spq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   entry_type slot_ff [CAPACITY];

   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic          rd_en;
   entry_type     rdata_ff;
   logic [AW-1:0] wr_addr_ff;
   logic [AW-1:0] wr_sel;
   entry_type     wr_data;
   logic          wr_en;
   logic [15:0]   req_id_ff;
   logic [7:0]    req_prio_ff;
   logic [7:0]    target_ff;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] emit_cnt_ff;
   logic          match;

   logic          rsp_valid_ff;
   logic [2:0]    rsp_status_ff;
   logic [15:0]   rsp_out_id_ff;
   logic [7:0]    rsp_out_priority_ff;
   logic          rsp_last_ff;
   logic [6:0]    rsp_occupancy_ff;

   assign match = (rdata_ff.prio == target_ff);

   always_comb begin
      sts.fill_zero  = (fill_ff == '0);
      sts.full       = (fill_ff == CW'(CAPACITY));
      sts.match      = match;
      sts.greater    = (rdata_ff.prio > req_prio_ff);
      sts.rd_zero    = (rd_addr_ff == '0);
      sts.at_end     = (CW'(rd_addr_ff) == fill_ff - 1'b1);
      sts.none_found = (cnt_ff == '0) && !match;
   end

   always_comb begin
      rd_en = 1'b1;
      case (cmd.rd_op)
         RD_TOP:  rd_addr_in = AW'(fill_ff - 1'b1);
         RD_ZERO: rd_addr_in = '0;
         RD_DN:   rd_addr_in = rd_addr_ff - 1'b1;
         RD_UP:   rd_addr_in = rd_addr_ff + 1'b1;
         default: begin
            rd_addr_in = rd_addr_ff;
            rd_en      = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_sel  = rd_addr_ff + 1'b1;
      wr_data = rdata_ff;
      case (cmd.wr_op)
         WR_SHIFT: begin
         end
         WR_NEW_ABOVE: wr_data = '{id: req_id_ff, prio: req_prio_ff};
         WR_NEW_ZERO: begin
            wr_sel  = '0;
            wr_data = '{id: req_id_ff, prio: req_prio_ff};
         end
         WR_KEEP: wr_sel = wr_addr_ff;
         default: wr_en = 1'b0;
      endcase
   end

   always_comb begin
      case (cmd.fill_op)
         FILL_INC:     fill_in = fill_ff + 1'b1;
         FILL_CLEAR:   fill_in = '0;
         FILL_SUB_CNT: fill_in = fill_ff - cnt_ff;
         default:      fill_in = fill_ff;
      endcase
   end

   // table memory, one read and one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_sel] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= slot_ff[rd_addr_in];
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      if (cmd.latch_req) begin
         req_id_ff   <= req_proc_id;
         req_prio_ff <= req_priority_req;
      end
      case (cmd.tgt_op)
         TGT_REQ:  target_ff <= req_priority_req;
         TGT_DATA: target_ff <= rdata_ff.prio;
         default: begin
         end
      endcase
      if (cmd.rd_op == RD_ZERO) begin
         wr_addr_ff  <= '0;
         emit_cnt_ff <= '0;
      end else begin
         if (cmd.wr_op == WR_KEEP) begin
            wr_addr_ff <= wr_addr_ff + 1'b1;
         end
         if (cmd.emit_op == EMIT_REMOVED) begin
            emit_cnt_ff <= emit_cnt_ff + 1'b1;
         end
      end
      case (cmd.cnt_op)
         CNT_CLEAR:     cnt_ff <= '0;
         CNT_INC_MATCH: cnt_ff <= cnt_ff + CW'(match);
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= (cmd.emit_op != EMIT_NONE);
      end
   end

   // response beat registers
   always_ff @(posedge clock) begin
      case (cmd.emit_op)
         EMIT_STATUS: begin
            rsp_status_ff       <= cmd.status;
            rsp_out_id_ff       <= '0;
            rsp_out_priority_ff <= '0;
            rsp_last_ff         <= 1'b1;
            rsp_occupancy_ff    <= 7'(fill_in);
         end
         EMIT_REMOVED: begin
            rsp_status_ff       <= ST_REMOVED;
            rsp_out_id_ff       <= rdata_ff.id;
            rsp_out_priority_ff <= rdata_ff.prio;
            rsp_last_ff         <= ((emit_cnt_ff + 1'b1) == cnt_ff);
            rsp_occupancy_ff    <= 7'(fill_ff - cnt_ff);
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_id       = rsp_out_id_ff;
   assign rsp_out_priority = rsp_out_priority_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_occupancy    = rsp_occupancy_ff;

endmodule

### hw/rtl/sorted_priority_queue_unit.sv
// sorted priority queue, one request at a time, up to CAPACITY entries in one memory
// insert: answers full when the table is full, else a top-down shift walk over the n entries held
// remove: a count pass over the n entries then a compaction pass;
// removed entries come out one beat each during the compaction pass
// clear, full, empty and no-match answer with one beat; the receiver cannot stall
// synchronous reset empties the table and drops busy and rsp_valid
module sorted_priority_queue_unit #(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_proc_id,
   input  logic [7:0]  req_priority_req,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_out_id,
   output logic [7:0]  rsp_out_priority,
   output logic        rsp_last,
   output logic [6:0]  rsp_occupancy
);
   import spq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .sts        (sts),
      .busy       (busy),
      .cmd        (cmd)
   );

   spq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_proc_id      (req_proc_id),
      .req_priority_req (req_priority_req),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_priority (rsp_out_priority),
      .rsp_last         (rsp_last),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule
